[rtl/core/arc_center_radius_check_unit_defines.svh]
// Assertion macros for the arc center/radius check unit.
// Taken in by the modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef ARC_CENTER_RADIUS_CHECK_UNIT_DEFINES_SVH
`define ARC_CENTER_RADIUS_CHECK_UNIT_DEFINES_SVH

// same-cycle implication
`define ACRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ACRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/acrc_pkg.sv]
// Package for the arc center/radius check unit: widths, tolerances, status codes,
// and the control record that rides along the pipeline. No dependencies.
`default_nettype none
package acrc_pkg;

	localparam int COORD_W   = 32;              // port coordinate width
	localparam int CW        = 32;              // coordinate bits taken from each field
	localparam int FRAC_BITS = 16;
	localparam int QW        = CW + 2;          // root width, one digit per sqrt cell
	localparam int RW        = 2 * QW;          // radicand width
	localparam int NW        = CW + QW;         // divide numerator width
	localparam int QB        = 42;              // quotient bits, one per divide cell
	localparam int CAP_BIT   = 40;              // term magnitude cap is 2^CAP_BIT
	localparam int RAD_W     = 31;

	localparam logic [QW-1:0] TOL_FINE = QW'(((5 << FRAC_BITS) + 500) / 1000);
	localparam logic [QW-1:0] TOL_HALF = QW'(1) << (FRAC_BITS - 1);

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_END    = 3'd1;
	localparam logic [2:0] ST_NO_OFFSET = 3'd2;
	localparam logic [2:0] ST_OVER_HALF = 3'd3;
	localparam logic [2:0] ST_OVER_PCT  = 3'd4;
	localparam logic [2:0] ST_TOO_SMALL = 3'd5;
	localparam logic [2:0] ST_ZERO_CHRD = 3'd6;

	localparam logic OP_CENTER = 1'b0;
	localparam logic OP_RADIUS = 1'b1;

	typedef struct packed {
		logic              op;
		logic              ccw;
		logic              rneg;
		logic [2:0]        status;
		logic signed [CW:0] dh;
		logic signed [CW:0] dv;
		logic signed [CW-1:0] oh;
		logic signed [CW-1:0] ov;
		logic [CW-1:0]     rm;
		logic [QW-1:0]     rr;
		logic              ovf_h;
		logic              ovf_v;
	} ctl_t;

endpackage
`default_nettype wire

[rtl/core/acrc_if.sv]
// Request and result channel interfaces of the arc center/radius check unit.
// Depends on acrc_pkg for field widths.
`default_nettype none
interface acrc_req_if;
	logic                               valid;
	logic                               ready;
	logic                               operation;
	logic [1:0]                         end_words;
	logic [1:0]                         offset_words;
	logic signed [acrc_pkg::COORD_W-1:0] target_h;
	logic signed [acrc_pkg::COORD_W-1:0] target_v;
	logic signed [acrc_pkg::COORD_W-1:0] start_h;
	logic signed [acrc_pkg::COORD_W-1:0] start_v;
	logic signed [acrc_pkg::COORD_W-1:0] offset_h;
	logic signed [acrc_pkg::COORD_W-1:0] offset_v;
	logic signed [acrc_pkg::COORD_W-1:0] radius_word;
	logic                               ccw;

	modport source (output valid, operation, end_words, offset_words, target_h, target_v,
		start_h, start_v, offset_h, offset_v, radius_word, ccw, input ready);
	modport sink (input valid, operation, end_words, offset_words, target_h, target_v,
		start_h, start_v, offset_h, offset_v, radius_word, ccw, output ready);
endinterface

interface acrc_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [2:0]                         status;
	logic signed [acrc_pkg::COORD_W-1:0] center_h;
	logic signed [acrc_pkg::COORD_W-1:0] center_v;
	logic [acrc_pkg::RAD_W-1:0]         radius_out;

	modport source (output valid, status, center_h, center_v, radius_out, input ready);
	modport sink (input valid, status, center_h, center_v, radius_out, output ready);
endinterface
`default_nettype wire

[rtl/core/acrc_sqrt_cell.sv]
// One digit of two parallel restoring square roots, plus the control record.
// Depends on acrc_pkg.
`default_nettype none
module acrc_sqrt_cell (
	input  logic                              clk,
	input  logic                              en,
	input  acrc_pkg::ctl_t                    ctl_i,
	input  logic [1:0][acrc_pkg::RW-1:0]      rad_i,
	input  logic [1:0][acrc_pkg::QW+1:0]      rem_i,
	input  logic [1:0][acrc_pkg::QW-1:0]      root_i,
	output acrc_pkg::ctl_t                    ctl_o,
	output logic [1:0][acrc_pkg::RW-1:0]      rad_o,
	output logic [1:0][acrc_pkg::QW+1:0]      rem_o,
	output logic [1:0][acrc_pkg::QW-1:0]      root_o
);
	localparam int QW = acrc_pkg::QW;
	localparam int RW = acrc_pkg::RW;

	logic [1:0][QW+1:0] rem_n;
	logic [1:0][QW+1:0] trial;
	logic [1:0]         ge;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			rem_n[l] = {rem_i[l][QW-1:0], rad_i[l][RW-1 -: 2]};
			trial[l] = {root_i[l], 2'b01};
			ge[l]    = rem_n[l] >= trial[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_o <= ctl_i;
			for (int l = 0; l < 2; l++) begin
				rad_o[l]  <= {rad_i[l][RW-3:0], 2'b00};
				rem_o[l]  <= ge[l] ? rem_n[l] - trial[l] : rem_n[l];
				root_o[l] <= {root_i[l][QW-2:0], ge[l]};
			end
		end
	end
endmodule
`default_nettype wire

[rtl/core/acrc_div_cell.sv]
// One quotient bit of two restoring divides sharing a divisor, plus the control record.
// Depends on acrc_pkg.
`default_nettype none
module acrc_div_cell (
	input  logic                         clk,
	input  logic                         en,
	input  acrc_pkg::ctl_t               ctl_i,
	input  logic [acrc_pkg::QW-1:0]      d_i,
	input  logic [1:0][acrc_pkg::QW-1:0] rem_i,
	input  logic [1:0][acrc_pkg::QB-1:0] num_i,
	input  logic [1:0][acrc_pkg::QB-1:0] quo_i,
	output acrc_pkg::ctl_t               ctl_o,
	output logic [acrc_pkg::QW-1:0]      d_o,
	output logic [1:0][acrc_pkg::QW-1:0] rem_o,
	output logic [1:0][acrc_pkg::QB-1:0] num_o,
	output logic [1:0][acrc_pkg::QB-1:0] quo_o
);
	localparam int QW = acrc_pkg::QW;
	localparam int QB = acrc_pkg::QB;

	logic [1:0][QW:0] rem_n;
	logic [1:0][QW:0] diff;
	logic [1:0]       ge;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			rem_n[l] = {rem_i[l], num_i[l][QB-1]};
			diff[l]  = rem_n[l] - {1'b0, d_i};
			ge[l]    = rem_n[l] >= {1'b0, d_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_o <= ctl_i;
			d_o   <= d_i;
			for (int l = 0; l < 2; l++) begin
				rem_o[l] <= ge[l] ? diff[l][QW-1:0] : rem_n[l][QW-1:0];
				num_o[l] <= {num_i[l][QB-2:0], 1'b0};
				quo_o[l] <= {quo_i[l][QB-2:0], ge[l]};
			end
		end
	end
endmodule
`default_nettype wire

[rtl/core/arc_center_radius_check_unit.sv]
// Channel   Dir  Contents
// arc_in    in   one arc block: words present, target, start, offsets, R, direction
// arc_out   out  status, center offset from start, radius
//
// Stages 1 to 3 lead into 34 square-root cells (two roots side by side), then stage 4
// and 42 divide cells (both center terms) in a row feed the result register.
// One request enters per cycle while the row is not held; the whole row advances together.
// The row holds only while its last cell has a result and the output register is full
// and not taken; a request is still accepted while a result waits and the last cell is empty.
// Reset clears the valid bits and the output valid; datapath registers are not reset.
`default_nettype none
`include "arc_center_radius_check_unit_defines.svh"
module arc_center_radius_check_unit (
	input  logic      clk,
	input  logic      arst_n,
	acrc_req_if.sink  arc_in,
	acrc_rsp_if.source arc_out
);
	localparam int CW  = acrc_pkg::CW;
	localparam int QW  = acrc_pkg::QW;
	localparam int RW  = acrc_pkg::RW;
	localparam int NW  = acrc_pkg::NW;
	localparam int QB  = acrc_pkg::QB;
	localparam int FW  = QB + 2;
	localparam int NST = 3 + QW + 1 + QB;

	logic en;
	logic in_fire;
	logic [NST-1:0] vld_q;
	logic out_valid_q;

	assign en       = arc_out.ready || !out_valid_q || !vld_q[NST-1];
	assign arc_in.ready = en;
	assign in_fire  = arc_in.valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_fire};
		end
	end

	// ---------------- stage 1: word selection, differences, magnitudes
	logic signed [CW-1:0] th_c, tv_c, oh_c, ov_c;
	logic signed [CW:0]   dh_c, dv_c;
	logic signed [CW+1:0] xb_c, yb_c;
	logic [CW-1:0]        mah_c, mav_c, rm_c;
	logic [CW:0]          mbh_c, mbv_c;
	acrc_pkg::ctl_t       ctl_c;

	always_comb begin
		th_c = arc_in.end_words[0] ? arc_in.target_h : arc_in.start_h;
		tv_c = arc_in.end_words[1] ? arc_in.target_v : arc_in.start_v;
		oh_c = arc_in.offset_words[0] ? arc_in.offset_h : '0;
		ov_c = arc_in.offset_words[1] ? arc_in.offset_v : '0;
		dh_c = {th_c[CW-1], th_c} - {arc_in.start_h[CW-1], arc_in.start_h};
		dv_c = {tv_c[CW-1], tv_c} - {arc_in.start_v[CW-1], arc_in.start_v};
		xb_c = {dh_c[CW], dh_c} - {{2{oh_c[CW-1]}}, oh_c};
		yb_c = {dv_c[CW], dv_c} - {{2{ov_c[CW-1]}}, ov_c};
		mah_c = oh_c[CW-1] ? CW'(-oh_c) : CW'(oh_c);
		mav_c = ov_c[CW-1] ? CW'(-ov_c) : CW'(ov_c);
		rm_c  = arc_in.radius_word[CW-1] ? CW'(-arc_in.radius_word) : CW'(arc_in.radius_word);
		if (arc_in.operation == acrc_pkg::OP_RADIUS) begin
			mbh_c = dh_c[CW] ? (CW+1)'(-dh_c) : (CW+1)'(dh_c);
			mbv_c = dv_c[CW] ? (CW+1)'(-dv_c) : (CW+1)'(dv_c);
		end else begin
			mbh_c = xb_c[CW+1] ? (CW+1)'(-xb_c) : (CW+1)'(xb_c);
			mbv_c = yb_c[CW+1] ? (CW+1)'(-yb_c) : (CW+1)'(yb_c);
		end
		ctl_c.op     = arc_in.operation;
		ctl_c.ccw    = arc_in.ccw;
		ctl_c.rneg   = arc_in.radius_word[CW-1];
		if (arc_in.end_words == 2'b00)
			ctl_c.status = acrc_pkg::ST_NO_END;
		else if (arc_in.operation == acrc_pkg::OP_CENTER && arc_in.offset_words == 2'b00)
			ctl_c.status = acrc_pkg::ST_NO_OFFSET;
		else
			ctl_c.status = acrc_pkg::ST_OK;
		ctl_c.dh    = dh_c;
		ctl_c.dv    = dv_c;
		ctl_c.oh    = oh_c;
		ctl_c.ov    = ov_c;
		ctl_c.rm    = rm_c;
		ctl_c.rr    = '0;
		ctl_c.ovf_h = 1'b0;
		ctl_c.ovf_v = 1'b0;
	end

	logic [CW-1:0]  mah_s1, mav_s1, rm_s1;
	logic [CW:0]    mbh_s1, mbv_s1;
	acrc_pkg::ctl_t ctl_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mah_s1 <= mah_c;
			mav_s1 <= mav_c;
			mbh_s1 <= mbh_c;
			mbv_s1 <= mbv_c;
			rm_s1  <= rm_c;
			ctl_s1 <= ctl_c;
		end
	end

	// ---------------- stage 2: squares
	logic [2*CW-1:0] sqah_s2, sqav_s2, r2_s2;
	logic [2*CW+1:0] sqbh_s2, sqbv_s2;
	acrc_pkg::ctl_t  ctl_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sqah_s2 <= mah_s1 * mah_s1;
			sqav_s2 <= mav_s1 * mav_s1;
			sqbh_s2 <= mbh_s1 * mbh_s1;
			sqbv_s2 <= mbv_s1 * mbv_s1;
			r2_s2   <= rm_s1 * rm_s1;
			ctl_s2  <= ctl_s1;
		end
	end

	// ---------------- stage 3: radicands and chord checks
	logic [RW-1:0]  sa_c, sb_c, r4_c, rada_c;
	acrc_pkg::ctl_t ctl3_c;

	always_comb begin
		sa_c   = RW'(sqah_s2) + RW'(sqav_s2);
		sb_c   = RW'(sqbh_s2) + RW'(sqbv_s2);
		r4_c   = {RW'(r2_s2)} << 2;
		rada_c = (ctl_s2.op == acrc_pkg::OP_RADIUS) ? r4_c - sb_c : sa_c;
		ctl3_c = ctl_s2;
		if (ctl_s2.status == acrc_pkg::ST_OK && ctl_s2.op == acrc_pkg::OP_RADIUS) begin
			if (r4_c < sb_c)
				ctl3_c.status = acrc_pkg::ST_TOO_SMALL;
			else if (sb_c == '0)
				ctl3_c.status = acrc_pkg::ST_ZERO_CHRD;
		end
	end

	logic [1:0][RW-1:0] rad_s3;
	acrc_pkg::ctl_t     ctl_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3 <= {sb_c, rada_c};
			ctl_s3 <= ctl3_c;
		end
	end

	// ---------------- square-root cells: lane 0 = r or t, lane 1 = rt or chord
	acrc_pkg::ctl_t             sq_ctl  [QW+1];
	logic [1:0][RW-1:0]         sq_rad  [QW+1];
	logic [1:0][QW+1:0]         sq_rem  [QW+1];
	logic [1:0][QW-1:0]         sq_root [QW+1];

	assign sq_ctl[0]  = ctl_s3;
	assign sq_rad[0]  = rad_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar i = 0; i < QW; i++) begin : g_sqrt
		acrc_sqrt_cell u_cell (
			.clk    (clk),
			.en     (en),
			.ctl_i  (sq_ctl[i]),
			.rad_i  (sq_rad[i]),
			.rem_i  (sq_rem[i]),
			.root_i (sq_root[i]),
			.ctl_o  (sq_ctl[i+1]),
			.rad_o  (sq_rad[i+1]),
			.rem_o  (sq_rem[i+1]),
			.root_o (sq_root[i+1])
		);
	end

	// ---------------- stage 4: radius check, numerators of the center terms
	logic [QW-1:0]   ra_c, rb_c, delta_c;
	logic [QW+9:0]   dpct_c;
	logic [CW-1:0]   adh_c, adv_c;
	acrc_pkg::ctl_t  ctl4_c;

	always_comb begin
		ra_c    = sq_root[QW][0];
		rb_c    = sq_root[QW][1];
		delta_c = (rb_c > ra_c) ? rb_c - ra_c : ra_c - rb_c;
		dpct_c  = (QW+10)'(delta_c) * (QW+10)'(1000);
		adh_c   = sq_ctl[QW].dh[CW] ? CW'(-sq_ctl[QW].dh) : CW'(sq_ctl[QW].dh);
		adv_c   = sq_ctl[QW].dv[CW] ? CW'(-sq_ctl[QW].dv) : CW'(sq_ctl[QW].dv);
		ctl4_c    = sq_ctl[QW];
		ctl4_c.rr = ra_c;
		if (sq_ctl[QW].status == acrc_pkg::ST_OK && sq_ctl[QW].op == acrc_pkg::OP_CENTER &&
			delta_c > acrc_pkg::TOL_FINE) begin
			if (delta_c > acrc_pkg::TOL_HALF)
				ctl4_c.status = acrc_pkg::ST_OVER_HALF;
			else if (dpct_c > (QW+10)'(ra_c))
				ctl4_c.status = acrc_pkg::ST_OVER_PCT;
		end
	end

	logic [1:0][NW-1:0] num_s4;
	logic [QW-1:0]      d_s4;
	acrc_pkg::ctl_t     ctl_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4[0] <= NW'(adv_c) * NW'(ra_c);
			num_s4[1] <= NW'(adh_c) * NW'(ra_c);
			d_s4      <= rb_c;
			ctl_s4    <= ctl4_c;
		end
	end

	// ---------------- divide head: a quotient that needs more than QB bits caps
	acrc_pkg::ctl_t       dv_ctl [QB+1];
	logic [QW-1:0]        dv_d   [QB+1];
	logic [1:0][QW-1:0]   dv_rem [QB+1];
	logic [1:0][QB-1:0]   dv_num [QB+1];
	logic [1:0][QB-1:0]   dv_quo [QB+1];
	acrc_pkg::ctl_t       ctl5_c;

	always_comb begin
		ctl5_c       = ctl_s4;
		ctl5_c.ovf_h = QW'(num_s4[0][NW-1:QB]) >= d_s4;
		ctl5_c.ovf_v = QW'(num_s4[1][NW-1:QB]) >= d_s4;
	end

	assign dv_ctl[0] = ctl5_c;
	assign dv_d[0]   = d_s4;
	assign dv_rem[0] = {QW'(num_s4[1][NW-1:QB]), QW'(num_s4[0][NW-1:QB])};
	assign dv_num[0] = {num_s4[1][QB-1:0], num_s4[0][QB-1:0]};
	assign dv_quo[0] = '0;

	for (genvar i = 0; i < QB; i++) begin : g_div
		acrc_div_cell u_cell (
			.clk   (clk),
			.en    (en),
			.ctl_i (dv_ctl[i]),
			.d_i   (dv_d[i]),
			.rem_i (dv_rem[i]),
			.num_i (dv_num[i]),
			.quo_i (dv_quo[i]),
			.ctl_o (dv_ctl[i+1]),
			.d_o   (dv_d[i+1]),
			.rem_o (dv_rem[i+1]),
			.num_o (dv_num[i+1]),
			.quo_o (dv_quo[i+1])
		);
	end

	// ---------------- final: sign, halve, saturate
	localparam logic [QB-1:0] CAP = QB'(1) << acrc_pkg::CAP_BIT;
	localparam logic signed [FW-1:0] SAT_HI = FW'((64'sd1 <<< (CW-1)) - 1);
	localparam logic signed [FW-1:0] SAT_LO = -FW'(64'sd1 <<< (CW-1));

	acrc_pkg::ctl_t         fc;
	logic [QB-1:0]          mh_c, mv_c;
	logic                   spos_c, posh_c, posv_c;
	logic signed [FW-1:0]   termh_c, termv_c, sumh_c, sumv_c, ch_c, cv_c;
	logic signed [CW-1:0]   chs_c, cvs_c;
	logic [CW-1:0]          rsel_c;
	logic [acrc_pkg::RAD_W-1:0] rad_c;
	logic [2:0]             st_c;
	logic signed [CW-1:0]   oh_o_c, ov_o_c;

	always_comb begin
		fc      = dv_ctl[QB];
		mh_c    = (fc.ovf_h || dv_quo[QB][0] > CAP) ? CAP : dv_quo[QB][0];
		mv_c    = (fc.ovf_v || dv_quo[QB][1] > CAP) ? CAP : dv_quo[QB][1];
		spos_c  = fc.ccw ^ fc.rneg;
		posh_c  = spos_c ^ fc.dv[CW];
		posv_c  = spos_c ^ fc.dh[CW];
		termh_c = posh_c ? FW'(mh_c) : -FW'(mh_c);
		termv_c = posv_c ? FW'(mv_c) : -FW'(mv_c);
		sumh_c  = FW'(fc.dh) - termh_c;
		sumv_c  = FW'(fc.dv) + termv_c;
		// halve toward zero
		ch_c    = $signed(sumh_c + FW'(sumh_c[FW-1])) >>> 1;
		cv_c    = $signed(sumv_c + FW'(sumv_c[FW-1])) >>> 1;
		chs_c   = (ch_c > SAT_HI) ? CW'(SAT_HI) : (ch_c < SAT_LO) ? CW'(SAT_LO) : CW'(ch_c);
		cvs_c   = (cv_c > SAT_HI) ? CW'(SAT_HI) : (cv_c < SAT_LO) ? CW'(SAT_LO) : CW'(cv_c);
		if (fc.op == acrc_pkg::OP_CENTER) begin
			rsel_c = (fc.rr > QW'({acrc_pkg::RAD_W{1'b1}})) ? CW'({acrc_pkg::RAD_W{1'b1}})
				: CW'(fc.rr);
			oh_o_c = fc.oh;
			ov_o_c = fc.ov;
		end else begin
			rsel_c = fc.rm;
			oh_o_c = chs_c;
			ov_o_c = cvs_c;
		end
		rad_c = (rsel_c > CW'({acrc_pkg::RAD_W{1'b1}})) ? {acrc_pkg::RAD_W{1'b1}}
			: rsel_c[acrc_pkg::RAD_W-1:0];
		st_c  = fc.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && vld_q[NST-1]) begin
			out_valid_q <= 1'b1;
		end else if (arc_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [2:0]                 status_q;
	logic signed [CW-1:0]       center_h_q, center_v_q;
	logic [acrc_pkg::RAD_W-1:0] radius_q;

	always_ff @(posedge clk) begin
		if (en && vld_q[NST-1]) begin
			status_q <= st_c;
			if (st_c == acrc_pkg::ST_OK) begin
				center_h_q <= oh_o_c;
				center_v_q <= ov_o_c;
				radius_q   <= rad_c;
			end else begin
				center_h_q <= '0;
				center_v_q <= '0;
				radius_q   <= '0;
			end
		end
	end

	assign arc_out.valid      = out_valid_q;
	assign arc_out.status     = status_q;
	assign arc_out.center_h   = acrc_pkg::COORD_W'(center_h_q);
	assign arc_out.center_v   = acrc_pkg::COORD_W'(center_v_q);
	assign arc_out.radius_out = radius_q;

	`ACRC_ASSERT_NOW(a_ready_when_tail_empty, !vld_q[NST-1], arc_in.ready, "pipe stalled with empty tail")
	`ACRC_ASSERT_NEXT(a_tail_lands, en && vld_q[NST-1], arc_out.valid, "result lost at tail")
	`ACRC_ASSERT_NOW(a_err_zero, arc_out.valid && arc_out.status != acrc_pkg::ST_OK, arc_out.center_h == '0 && arc_out.center_v == '0 && arc_out.radius_out == '0, "error result carries data")
	`ACRC_ASSERT_NOW(a_status_code, arc_out.valid, arc_out.status != 3'd7, "undefined status code")

endmodule
`default_nettype wire
